FILE: src/sofcrc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the serial frame receiver.
package sofcrc_pkg;

  localparam int unsigned HDR_BYTES = 7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [31:0] START_RESET = 32'hA5B5C5D5;

  // Frame status codes carried on a result.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
  localparam logic [1:0] STATUS_ZERO_LEN  = 2'd2;
  localparam logic [1:0] STATUS_BAD_START = 2'd3;

  // One result as handed from the frame engine to the output register.
  typedef struct packed {
    logic       is_payload;
    logic [7:0] data_byte;
    logic       end_of_frame;
    logic [1:0] frame_status;
  } result_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

FILE: src/sofcrc_core.sv
// Frame engine: header parsing, start word resync, payload pass-through and CRC check.
module sofcrc_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               rx_byte,
  input  logic                     line_error,
  input  logic                     cfg_write,
  input  logic [31:0]              cfg_data,
  output logic                     res_valid,
  output sofcrc_pkg::result_t      res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RESYNC  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [2:0] HDR_LAST = 3'(sofcrc_pkg::HDR_BYTES);

  logic [31:0] start_word;
  logic [1:0]  phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        start_match_ok, start_match_ok_next;
  logic [1:0]  resync_fill, resync_fill_next;
  logic [15:0] expected_crc, expected_crc_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;

  logic [15:0] crc_seed;
  logic [15:0] crc_new;
  logic [2:0]  hdr_count;
  logic [2:0]  hdr_count_inc;
  logic [7:0]  pay_count_inc;
  logic        hdr_ok;

  function automatic logic [7:0] sel_byte(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = word[7:0];
      2'd1:    r = word[15:8];
      2'd2:    r = word[23:16];
      default: r = word[31:24];
    endcase
    return r;
  endfunction

  // The same CRC unit serves the first header update and every payload byte.
  assign crc_seed = (phase == PH_PAYLOAD) ? running_crc : sofcrc_pkg::CRC_INIT;
  assign crc_new  = sofcrc_pkg::crc_byte(crc_seed, rx_byte);

  assign hdr_count     = (byte_count > 8'd6) ? 3'd0 : byte_count[2:0];
  assign hdr_count_inc = hdr_count + 3'd1;
  assign pay_count_inc = byte_count + 8'd1;
  assign hdr_ok        = start_match_ok &&
                         !((hdr_count < 3'd4) && (rx_byte != sel_byte(start_word, hdr_count[1:0])));

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    start_match_ok_next = start_match_ok;
    resync_fill_next    = resync_fill;
    expected_crc_next   = expected_crc;
    frame_length_next   = frame_length;
    running_crc_next    = running_crc;
    res_valid           = 1'b0;
    res                 = '0;

    if (step) begin
      unique case (phase)
        PH_RESYNC: begin
          if (!line_error) begin
            if (rx_byte == sel_byte(start_word, resync_fill)) begin
              if (resync_fill == 2'd3) begin
                resync_fill_next    = 2'd0;
                phase_next          = PH_HEADER;
                byte_count_next     = 8'd4;
                start_match_ok_next = 1'b1;
              end else begin
                resync_fill_next = resync_fill + 2'd1;
              end
            end else begin
              resync_fill_next = (rx_byte == sel_byte(start_word, 2'd0)) ? 2'd1 : 2'd0;
            end
          end
        end
        PH_PAYLOAD: begin
          if (line_error) begin
            phase_next          = PH_HEADER;
            byte_count_next     = 8'd0;
            start_match_ok_next = 1'b1;
          end else begin
            running_crc_next = crc_new;
            byte_count_next  = pay_count_inc;
            res_valid        = 1'b1;
            res.is_payload   = 1'b1;
            res.data_byte    = rx_byte;
            if (pay_count_inc == frame_length) begin
              res.end_of_frame    = 1'b1;
              res.frame_status    = (crc_new == expected_crc) ? sofcrc_pkg::STATUS_OK
                                                              : sofcrc_pkg::STATUS_CRC_ERR;
              phase_next          = PH_HEADER;
              byte_count_next     = 8'd0;
              start_match_ok_next = 1'b1;
            end
          end
        end
        default: begin
          // Header collection; the unused phase code behaves the same way.
          if (line_error) begin
            phase_next          = PH_HEADER;
            byte_count_next     = 8'd0;
            start_match_ok_next = 1'b1;
          end else begin
            if (hdr_count == 3'd4) begin
              expected_crc_next = {expected_crc[15:8], rx_byte};
            end else if (hdr_count == 3'd5) begin
              expected_crc_next = {rx_byte, expected_crc[7:0]};
            end else if (hdr_count >= 3'd6) begin
              frame_length_next = rx_byte;
            end

            if (hdr_count_inc == HDR_LAST) begin
              res_valid = 1'b1;
              if (!hdr_ok) begin
                res.frame_status    = sofcrc_pkg::STATUS_BAD_START;
                phase_next          = PH_RESYNC;
                resync_fill_next    = 2'd0;
                byte_count_next     = 8'd0;
                start_match_ok_next = 1'b1;
              end else if (rx_byte == 8'd0) begin
                res.frame_status    = sofcrc_pkg::STATUS_ZERO_LEN;
                phase_next          = PH_HEADER;
                byte_count_next     = 8'd0;
                start_match_ok_next = 1'b1;
              end else begin
                res_valid           = 1'b0;
                running_crc_next    = crc_new;
                phase_next          = PH_PAYLOAD;
                byte_count_next     = 8'd0;
                start_match_ok_next = 1'b1;
              end
            end else begin
              byte_count_next     = {5'd0, hdr_count_inc};
              start_match_ok_next = hdr_ok;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_word     <= sofcrc_pkg::START_RESET;
      phase          <= PH_HEADER;
      byte_count     <= 8'd0;
      start_match_ok <= 1'b1;
      resync_fill    <= 2'd0;
      expected_crc   <= 16'h0000;
      frame_length   <= 8'd0;
      running_crc    <= sofcrc_pkg::CRC_INIT;
    end else begin
      if (cfg_write) begin
        start_word <= cfg_data;
      end
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      start_match_ok <= start_match_ok_next;
      resync_fill    <= resync_fill_next;
      expected_crc   <= expected_crc_next;
      frame_length   <= frame_length_next;
      running_crc    <= running_crc_next;
    end
  end

endmodule

FILE: src/sof_crc_frame_receiver_unit.sv
// Top level of the cut-through serial frame receiver with start word resync and CRC-16 check.
//
// The receiver takes one line byte per request and parses frames of the form start word
// (4 bytes, least significant first), CRC-16 (2 bytes, low first), length byte, payload.
// Payload bytes leave as they arrive, one result per byte, and the last one carries
// end_of_frame and the CRC-16/CCITT-FALSE verdict computed over the length byte and the
// payload. A header whose start word is wrong gives one result with the bad start status,
// after which the receiver slides over single bytes until the start word appears and then
// reads the remaining three header bytes. A zero length gives one result with the zero
// length status. A line error drops the byte and restarts the header, except during the
// resync search, which simply skips it. Other header bytes and resync bytes give no result.
// The block sustains one request per clock cycle unless the output register holds the
// pipeline: a request is taken into an input register, the frame engine processes it
// through one byte-wide CRC update and compare, and its result, if any, is loaded into
// the output register. The output register only holds the pipeline when a result
// sits in it and the consumer stalls.
// The start word register is written through cfg_write and cfg_data and must only be
// changed while no request is in flight; it resets to 0xA5B5C5D5.
module sof_crc_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        line_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_payload,
  output logic [7:0]  data_byte,
  output logic        end_of_frame,
  output logic [1:0]  frame_status,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  // Input register stage.
  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_error;

  // The pipeline moves whenever the output register is free or being emptied.
  logic advance;
  logic in_accept;

  logic                res_valid;
  sofcrc_pkg::result_t res;
  sofcrc_pkg::result_t out_reg;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_byte  <= rx_byte;
      in_reg_error <= line_error;
    end
  end

  sofcrc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (in_reg_valid && advance),
    .rx_byte    (in_reg_byte),
    .line_error (in_reg_error),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register: loaded on every advance, so an empty slot drops out_valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign is_payload   = out_reg.is_payload;
  assign data_byte    = out_reg.data_byte;
  assign end_of_frame = out_reg.end_of_frame;
  assign frame_status = out_reg.frame_status;

endmodule

FILE: src/sofcrc_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module sofcrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_payload,
  input logic [7:0]  data_byte,
  input logic        end_of_frame,
  input logic [1:0]  frame_status
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(frame_status)
      && $stable(is_payload) && $stable(end_of_frame))
    else $error("stalled result changed");

  // End of frame is only ever flagged on a payload byte.
  a_eof_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> is_payload)
    else $error("end_of_frame on a non-payload result");

  // Payload bytes before the last carry no verdict.
  a_mid_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_payload && !end_of_frame |-> frame_status == sofcrc_pkg::STATUS_OK)
    else $error("verdict on a middle payload byte");

  // A header verdict is either a bad start word or a zero length, with no data.
  a_hdr_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_payload |->
      (frame_status == sofcrc_pkg::STATUS_BAD_START
       || frame_status == sofcrc_pkg::STATUS_ZERO_LEN) && data_byte == 8'd0)
    else $error("malformed header verdict");

endmodule

bind sof_crc_frame_receiver_unit sofcrc_checker u_sofcrc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .is_payload   (is_payload),
  .data_byte    (data_byte),
  .end_of_frame (end_of_frame),
  .frame_status (frame_status)
);

FILE: bench/tb_sof_crc_frame_receiver_unit.sv
// Self-checking testbench for the serial frame receiver: directed and random line traffic.
module tb_sof_crc_frame_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The settle count gives margin for results still in the pipe before the start word
  // is rewritten, and the tail count also covers the longest output stall, so a stray
  // result is still caught at the end.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned PHASE_BYTES = 190;
  localparam int unsigned RANDOM_PHASES = 6;

  // One entry of the line script: either a received byte or a new start word.
  typedef enum logic {ACT_BYTE, ACT_SET_START} line_act_e;

  typedef struct {
    line_act_e   kind;
    logic [7:0]  rx;
    logic        err;
    logic [31:0] word;
  } line_act_t;

  // Parser phases of the receiver as the predictor tracks them.
  typedef enum logic [1:0] {PH_COLLECT, PH_SEARCH, PH_PAYLOAD} rx_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        line_error = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_payload;
  logic [7:0]  data_byte;
  logic        end_of_frame;
  logic [1:0]  frame_status;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = 32'h0000_0000;

  // Script of line activity, filled once at time zero and drained by the line driver.
  line_act_t pending_actions[$];
  int unsigned queued_bytes = 0;

  // Results the receiver owes us, oldest first.
  sofcrc_pkg::result_t frame_results[$];
  int unsigned fault_count = 0;

  // Predictor state: a private copy of the receiver's parser and of its start word.
  logic [31:0] live_start_word = sofcrc_pkg::START_RESET;
  rx_phase_e   rx_phase = PH_COLLECT;
  logic [7:0]  frame_pos = 8'd0;
  logic        start_ok = 1'b1;
  logic [1:0]  window_fill = 2'd0;
  logic [15:0] hdr_crc = 16'h0000;
  logic [7:0]  hdr_len = 8'd0;
  logic [15:0] payload_crc = sofcrc_pkg::CRC_INIT;

  // Pacing state of both sides.
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned quiet_cycles = 0;
  int unsigned recv_hold = 0;
  int unsigned recv_calm = 0;

  sof_crc_frame_receiver_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .line_error   (line_error),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_payload   (is_payload),
    .data_byte    (data_byte),
    .end_of_frame (end_of_frame),
    .frame_status (frame_status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16/CCITT-FALSE, one byte fed in bit by bit, most significant bit first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? sofcrc_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // Start word bytes are expected least significant first on the line.
  function automatic logic [7:0] start_byte_at(input logic [1:0] idx);
    return live_start_word[8 * idx +: 8];
  endfunction

  function automatic void restart_header();
    rx_phase = PH_COLLECT;
    frame_pos = 8'd0;
    start_ok = 1'b1;
  endfunction

  // Advance the predicted parser by one accepted request and queue the result it owes.
  function automatic void advance_receiver(input logic [7:0] b, input logic err);
    sofcrc_pkg::result_t r;
    r = '0;
    case (rx_phase)
      PH_SEARCH: begin
        // The search skips bad bytes. A mismatch restarts the window, which keeps one
        // byte when the mismatching byte itself equals the first start byte.
        if (!err) begin
          if (b == start_byte_at(window_fill)) begin
            if (window_fill == 2'd3) begin
              window_fill = 2'd0;
              rx_phase = PH_COLLECT;
              frame_pos = 8'd4;
              start_ok = 1'b1;
            end else begin
              window_fill = window_fill + 2'd1;
            end
          end else begin
            window_fill = (b == start_byte_at(2'd0)) ? 2'd1 : 2'd0;
          end
        end
      end
      PH_PAYLOAD: begin
        // A line error aborts the frame silently; no end of frame is ever reported.
        if (err) begin
          restart_header();
        end else begin
          payload_crc = crc16_step(payload_crc, b);
          frame_pos = frame_pos + 8'd1;
          r.is_payload = 1'b1;
          r.data_byte = b;
          if (frame_pos == hdr_len) begin
            r.end_of_frame = 1'b1;
            r.frame_status = (payload_crc == hdr_crc) ? sofcrc_pkg::STATUS_OK
                                                      : sofcrc_pkg::STATUS_CRC_ERR;
            restart_header();
          end
          frame_results.push_back(r);
        end
      end
      default: begin
        if (err) begin
          restart_header();
        end else begin
          if (frame_pos < 8'd4) begin
            if (b != start_byte_at(frame_pos[1:0])) begin
              start_ok = 1'b0;
            end
          end else if (frame_pos == 8'd4) begin
            hdr_crc[7:0] = b;
          end else if (frame_pos == 8'd5) begin
            hdr_crc[15:8] = b;
          end else begin
            hdr_len = b;
          end
          frame_pos = frame_pos + 8'd1;
          // The header verdict comes only once all seven header bytes are in.
          if (frame_pos == sofcrc_pkg::HDR_BYTES) begin
            if (!start_ok) begin
              rx_phase = PH_SEARCH;
              window_fill = 2'd0;
              frame_pos = 8'd0;
              start_ok = 1'b1;
              r.frame_status = sofcrc_pkg::STATUS_BAD_START;
              frame_results.push_back(r);
            end else if (hdr_len == 8'd0) begin
              restart_header();
              r.frame_status = sofcrc_pkg::STATUS_ZERO_LEN;
              frame_results.push_back(r);
            end else begin
              payload_crc = crc16_step(sofcrc_pkg::CRC_INIT, hdr_len);
              rx_phase = PH_PAYLOAD;
              frame_pos = 8'd0;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic err);
    line_act_t a;
    a.kind = ACT_BYTE;
    a.rx = b;
    a.err = err;
    a.word = 32'h0000_0000;
    pending_actions.push_back(a);
    queued_bytes++;
  endfunction

  // Queue one complete frame with a random payload. A good or a deliberately broken CRC
  // is placed in the header. When cut names a byte position, a line error byte replaces
  // that byte and the rest of the frame is never sent.
  function automatic void queue_frame(input logic [31:0] word, input int len,
                                      input bit crc_ok, input int cut);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    logic [7:0]  pay;
    crc = crc16_step(sofcrc_pkg::CRC_INIT, len[7:0]);
    for (int k = 0; k < 4; k++) begin
      frame_bytes.push_back(word[8 * k +: 8]);
    end
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(len[7:0]);
    for (int k = 0; k < len; k++) begin
      pay = 8'($urandom_range(0, 255));
      frame_bytes.push_back(pay);
      crc = crc16_step(crc, pay);
    end
    if (!crc_ok) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    frame_bytes[4] = crc[7:0];
    frame_bytes[5] = crc[15:8];
    for (int k = 0; k < frame_bytes.size(); k++) begin
      if (k == cut) begin
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
        break;
      end
      queue_byte(frame_bytes[k], 1'b0);
    end
  endfunction

  // Line driver. Each request waits a random gap, with occasional calm stretches of
  // back-to-back requests. A held request keeps its payload until accepted.
  // A new start word is written only once every owed result has arrived and the pipe has
  // settled, which also makes the sender pause until the receiver has fully drained.
  always @(posedge clk) begin : line_driver
    line_act_t act;
    logic      next_valid;
    logic      next_cfg;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_write <= 1'b0;
      send_gap = 0;
      quiet_cycles = 0;
    end else begin
      next_valid = in_valid;
      next_cfg = 1'b0;
      if (in_valid && !in_stall) begin
        advance_receiver(rx_byte, line_error);
        next_valid = 1'b0;
      end
      if (!next_valid && pending_actions.size() != 0) begin
        act = pending_actions[0];
        if (act.kind == ACT_BYTE) begin
          quiet_cycles = 0;
          if (send_gap != 0) begin
            send_gap--;
          end else begin
            rx_byte <= act.rx;
            line_error <= act.err;
            next_valid = 1'b1;
            void'(pending_actions.pop_front());
            if (send_calm != 0) begin
              send_calm--;
              send_gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
              send_calm = $urandom_range(16, 64);
              send_gap = 0;
            end else begin
              send_gap = $urandom_range(0, 15);
            end
          end
        end else if (frame_results.size() != 0) begin
          quiet_cycles = 0;
        end else if (quiet_cycles < SETTLE_CYCLES) begin
          quiet_cycles++;
        end else begin
          cfg_data <= act.word;
          next_cfg = 1'b1;
          live_start_word = act.word;
          void'(pending_actions.pop_front());
          quiet_cycles = 0;
        end
      end
      in_valid <= next_valid;
      cfg_write <= next_cfg;
    end
  end

  // Result monitor. Every accepted result is checked field by field against the oldest
  // owed one. After each result the consumer draws a random stall, which may be none,
  // again with calm stretches where it never stalls.
  always @(posedge clk) begin : result_monitor
    sofcrc_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          $error("unexpected result: is_payload %0d data_byte 0x%02h end_of_frame %0d %s %0d",
                 is_payload, data_byte, end_of_frame, "frame_status", frame_status);
          fault_count++;
        end else begin
          want = frame_results.pop_front();
          if (is_payload !== want.is_payload) begin
            $error("is_payload: expected %0d, actual %0d", want.is_payload, is_payload);
            fault_count++;
          end
          if (data_byte !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, actual 0x%02h", want.data_byte, data_byte);
            fault_count++;
          end
          if (end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0d, actual %0d", want.end_of_frame, end_of_frame);
            fault_count++;
          end
          if (frame_status !== want.frame_status) begin
            $error("frame_status: expected %0d, actual %0d", want.frame_status, frame_status);
            fault_count++;
          end
        end
        if (recv_calm != 0) begin
          recv_calm--;
          recv_hold = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          recv_calm = $urandom_range(16, 64);
          recv_hold = 0;
        end else begin
          recv_hold = $urandom_range(0, 15);
        end
      end else if (recv_hold != 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold != 0);
    end
  end

  // Stimulus script and end of run.
  initial begin : stimulus
    logic [31:0] word;
    logic [7:0]  b;
    line_act_t   set_act;
    int unsigned target;
    int unsigned pick;
    int          len;
    int          spoil;

    // Directed part, under the start word that reset leaves in place.
    // A line error in the middle of a header throws the partial header away.
    queue_byte(8'hD5, 1'b0);
    queue_byte(8'hC5, 1'b0);
    queue_byte(8'h00, 1'b1);
    // A well-formed header announcing an empty frame.
    queue_frame(sofcrc_pkg::START_RESET, 0, 1'b1, -1);
    // A header with a wrong first start byte is read in full and then reported.
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hC5, 1'b0);
    queue_byte(8'hB5, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    // During the search a line error is skipped, a repeated first start byte keeps the
    // window at one, and an unrelated byte empties it.
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'hD5, 1'b0);
    queue_byte(8'hD5, 1'b0);
    queue_byte(8'h3C, 1'b0);
    // The start word is found; the tail carries a CRC that does not fit a zero payload.
    queue_byte(8'hD5, 1'b0);
    queue_byte(8'hC5, 1'b0);
    queue_byte(8'hB5, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h00, 1'b0);

    // Random part in phases, each under its own start word, the extremes among them.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: word = 32'hFFFF_FFFF;
        2: word = 32'h0000_0000;
        4: word = sofcrc_pkg::START_RESET;
        default: word = $urandom;
      endcase
      set_act.kind = ACT_SET_START;
      set_act.rx = 8'h00;
      set_act.err = 1'b0;
      set_act.word = word;
      pending_actions.push_back(set_act);
      // One frame of the largest length, the rest kept short.
      if (ph == 3) begin
        queue_frame(word, 255, 1'b1, -1);
      end
      target = queued_bytes + PHASE_BYTES;
      while (queued_bytes < target) begin
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 31) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        if (pick < 50) begin
          queue_frame(word, len, 1'b1, -1);
        end else if (pick < 60) begin
          queue_frame(word, len, 1'b0, -1);
        end else if (pick < 67) begin
          queue_frame(word, 0, 1'b1, -1);
        end else if (pick < 80) begin
          // Header with one corrupted start byte, some line junk, then a frame that the
          // search has to find. Sometimes a line error hits the tail or the payload.
          spoil = $urandom_range(0, 3);
          for (int k = 0; k < 7; k++) begin
            b = (k < 4) ? word[8 * k +: 8] : 8'($urandom_range(0, 255));
            if (k == spoil) begin
              b = b ^ (8'h01 << $urandom_range(0, 7));
            end
            queue_byte(b, 1'b0);
          end
          repeat ($urandom_range(0, 6)) begin
            queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
          end
          queue_frame(word, len, ($urandom_range(0, 3) != 0),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6 + len) : -1);
        end else if (pick < 92) begin
          queue_frame(word, len, 1'b1, $urandom_range(0, 6 + len));
        end else begin
          // Line noise, closed by a line error so that the next header starts clean.
          repeat ($urandom_range(1, 10)) begin
            queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
          end
          queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_actions.size() != 0 || in_valid) @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/sofcrc_pkg.sv
src/sofcrc_core.sv
src/sof_crc_frame_receiver_unit.sv
src/sofcrc_checker.sv
bench/tb_sof_crc_frame_receiver_unit.sv
